// ----- src/llc_pkg.sv -----
// Shared types and constants for the loopback latency compensator
package llc_pkg;

    localparam int DELAY_DEPTH = 65536;
    localparam int CHANNELS    = 7;
    localparam int HISTORY_LEN = 8;
    localparam int AW          = $clog2(DELAY_DEPTH);
    localparam int CW          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HW          = $clog2(HISTORY_LEN);
    localparam int SW          = 24 + HW;
    localparam logic [23:0] MAX24 = 24'hFFFFFF;

    typedef enum logic [2:0] {
        REG_PULSE_LENGTH = 3'd0,
        REG_MIN_TIMEOUT  = 3'd1,
        REG_TIMEOUT_STEP = 3'd2,
        REG_MAX_TIMEOUT  = 3'd3,
        REG_HIGH_THRESH  = 3'd4,
        REG_LOW_THRESH   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] loop_level;
        logic               loop_patched;
        logic               mirror_enable;
        logic [23:0]        mirror_delay;
        logic               reset_pressed;
        logic signed [15:0] chan0_in;
        logic signed [15:0] chan1_in;
        logic signed [15:0] chan2_in;
        logic signed [15:0] chan3_in;
        logic signed [15:0] chan4_in;
        logic signed [15:0] chan5_in;
        logic signed [15:0] chan6_in;
    } in_item_t;

    typedef struct packed {
        logic               loop_pulse;
        logic [23:0]        measured_delay;
        logic               new_measurement;
        logic signed [15:0] chan0_out;
        logic signed [15:0] chan1_out;
        logic signed [15:0] chan2_out;
        logic signed [15:0] chan3_out;
        logic signed [15:0] chan4_out;
        logic signed [15:0] chan5_out;
        logic signed [15:0] chan6_out;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic          load;     // capture item, run measurement update
        logic          hist_add; // accumulate history entry hist_idx
        logic [HW-1:0] hist_idx;
        logic          finish;   // apply mean and timeout
        logic          tap;      // access store for channel ch
        logic [CW-1:0] ch;
        logic          advance;  // bump write pointer
    } llc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic recorded;
        logic delay_nz;
    } llc_sts_t;

endpackage

// ----- src/llc_ctrl.sv -----
// Sequencer for the loopback latency compensator
module llc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  llc_pkg::llc_sts_t   sts,
    output llc_pkg::llc_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_HIST, S_FIN, S_TAP, S_DRAIN, S_DONE
    } state_t;

    state_t                    state_reg;
    logic [llc_pkg::HW-1:0]    cnt_reg;
    logic [llc_pkg::CW:0]      ch_reg;
    logic                      ovalid_reg;

    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = in_valid && in_ready;
        cmd.hist_idx = cnt_reg;
        cmd.hist_add = (state_reg == S_HIST);
        cmd.finish   = (state_reg == S_FIN);
        cmd.ch       = ch_reg[llc_pkg::CW-1:0];
        cmd.tap      = (state_reg == S_TAP);
        cmd.advance  = (state_reg == S_DRAIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ch_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (cmd.load)
                    begin
                        cnt_reg   <= '0;
                        ch_reg    <= '0;
                        state_reg <= S_HIST;
                    end
                S_HIST:
                    if (!sts.recorded)
                        state_reg <= S_FIN;
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == llc_pkg::HW'(llc_pkg::HISTORY_LEN - 1))
                            state_reg <= S_FIN;
                    end
                S_FIN:
                    state_reg <= sts.delay_nz ? S_TAP : S_DONE;
                S_TAP:
                begin
                    ch_reg <= ch_reg + 1'b1;
                    if (ch_reg == (llc_pkg::CW + 1)'(llc_pkg::CHANNELS - 1))
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                    state_reg <= S_DONE;
                S_DONE:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready while busy");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("result missing");
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !out_valid)
        else $error("accept with pending result");

endmodule

// ----- src/llc_datapath.sv -----
// Measurement state, history, timeout and channel delay store
module llc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    input  llc_pkg::in_item_t    in_item,
    input  llc_pkg::llc_cmd_t    cmd,
    output llc_pkg::llc_sts_t    sts,
    output llc_pkg::out_item_t   out_item
);

    localparam int AW = llc_pkg::AW;
    localparam int HW = llc_pkg::HW;
    localparam int SW = llc_pkg::SW;

    logic [15:0]        pulse_length_reg;
    logic [23:0]        min_timeout_reg, timeout_step_reg, max_timeout_reg;
    logic signed [15:0] high_thr_reg, low_thr_reg;

    logic [1:0]         phase_reg;
    logic [23:0]        wait_count_reg, timeout_reg, delay_reg;
    logic [23:0]        hist_reg [llc_pkg::HISTORY_LEN];
    logic [HW-1:0]      hptr_reg;
    logic [15:0]        pulse_rem_reg;
    logic [AW-1:0]      wptr_reg;
    logic               wrapped_reg;
    logic [15:0]        held_reg [llc_pkg::CHANNELS];
    logic               recorded_reg, timed_out_reg, pulse_reg;
    logic [SW-1:0]      sum_reg;
    logic [23:0]        max_reg;
    llc_pkg::in_item_t  item_reg;

    logic [15:0] mem [llc_pkg::CHANNELS * llc_pkg::DELAY_DEPTH];
    logic [15:0] rdata_reg;
    logic        rblank_reg;
    logic        rvalid_reg;
    logic [llc_pkg::CW-1:0] rch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_length_reg <= 16'd240;
            min_timeout_reg  <= 24'd9600;
            timeout_step_reg <= 24'd48000;
            max_timeout_reg  <= 24'd58982;
            high_thr_reg     <= 16'sd16384;
            low_thr_reg      <= 16'sd3277;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                llc_pkg::REG_PULSE_LENGTH: pulse_length_reg <= cfg_data[15:0];
                llc_pkg::REG_MIN_TIMEOUT:  min_timeout_reg  <= cfg_data;
                llc_pkg::REG_TIMEOUT_STEP: timeout_step_reg <= cfg_data;
                llc_pkg::REG_MAX_TIMEOUT:  max_timeout_reg  <= cfg_data;
                llc_pkg::REG_HIGH_THRESH:  high_thr_reg     <= cfg_data[15:0];
                llc_pkg::REG_LOW_THRESH:   low_thr_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic        measuring;
    logic [23:0] wc_inc;
    logic [23:0] hist_val;
    logic [24:0] to_sum;
    logic [55:0] max_prod;
    logic [24:0] max_q;
    logic [23:0] max_div;
    logic [15:0] din;
    logic [AW-1:0] ridx, rptr;

    assign measuring = !in_item.mirror_enable && in_item.loop_patched
                       && !in_item.reset_pressed;
    assign wc_inc    = (wait_count_reg < llc_pkg::MAX24) ? wait_count_reg + 24'd1
                                                         : wait_count_reg;
    assign hist_val  = hist_reg[cmd.hist_idx];
    assign to_sum    = {1'b0, timeout_reg} + {1'b0, timeout_step_reg};
    // times 11/10: multiply by 11*ceil(2^31/10) and shift, then saturate
    assign max_prod  = {32'd0, max_reg} * 56'd2362232015;
    assign max_q     = max_prod[55:31];
    assign max_div   = (max_q > {1'b0, llc_pkg::MAX24}) ? llc_pkg::MAX24 : max_q[23:0];

    always_comb
    begin
        case (cmd.ch)
            3'd0:    din = item_reg.chan0_in;
            3'd1:    din = item_reg.chan1_in;
            3'd2:    din = item_reg.chan2_in;
            3'd3:    din = item_reg.chan3_in;
            3'd4:    din = item_reg.chan4_in;
            3'd5:    din = item_reg.chan5_in;
            default: din = item_reg.chan6_in;
        endcase
    end

    assign ridx = (delay_reg > 24'(llc_pkg::DELAY_DEPTH - 1))
                  ? AW'(llc_pkg::DELAY_DEPTH - 1) : delay_reg[AW-1:0];
    assign rptr = wptr_reg - ridx;

    always_ff @(posedge clk)
    begin
        if (cmd.tap)
            mem[{cmd.ch, wptr_reg}] <= din;
        rdata_reg  <= mem[{cmd.ch, rptr}];
        rblank_reg <= !wrapped_reg && (rptr >= wptr_reg);
        rch_reg    <= cmd.ch;
        if (cmd.load)
            item_reg <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 2'd0;
            wait_count_reg <= '0;
            timeout_reg    <= 24'd9600;
            hptr_reg       <= '0;
            delay_reg      <= '0;
            pulse_rem_reg  <= '0;
            wptr_reg       <= '0;
            wrapped_reg    <= 1'b0;
            recorded_reg   <= 1'b0;
            timed_out_reg  <= 1'b0;
            pulse_reg      <= 1'b0;
            sum_reg        <= '0;
            max_reg        <= '0;
            rvalid_reg     <= 1'b0;
            for (int i = 0; i < llc_pkg::HISTORY_LEN; i++)
                hist_reg[i] <= '0;
            for (int i = 0; i < llc_pkg::CHANNELS; i++)
                held_reg[i] <= '0;
        end
        else
        begin
            rvalid_reg <= cmd.tap;
            if (rvalid_reg)
                held_reg[rch_reg] <= rblank_reg ? 16'd0 : rdata_reg;
            if (cmd.load)
            begin
                logic [15:0] pr;
                pr           = pulse_rem_reg;
                recorded_reg <= 1'b0;
                sum_reg      <= '0;
                max_reg      <= '0;
                if (measuring)
                begin
                    if (phase_reg == 2'd1)
                    begin
                        wait_count_reg <= wc_inc;
                        if (in_item.loop_level > high_thr_reg || wc_inc > timeout_reg)
                        begin
                            timed_out_reg      <= wc_inc > timeout_reg;
                            hist_reg[hptr_reg] <= wc_inc;
                            hptr_reg           <= hptr_reg + 1'b1;
                            recorded_reg       <= 1'b1;
                            phase_reg          <= 2'd2;
                        end
                    end
                    else if (phase_reg == 2'd2)
                    begin
                        if (in_item.loop_level < low_thr_reg)
                            phase_reg <= 2'd0;
                    end
                    else
                    begin
                        if (pulse_length_reg > pr)
                            pr = pulse_length_reg;
                        wait_count_reg <= '0;
                        phase_reg      <= 2'd1;
                    end
                end
                else
                begin
                    phase_reg <= 2'd0;
                    if (in_item.mirror_enable)
                        delay_reg <= in_item.mirror_delay;
                end
                pulse_reg     <= pr != '0;
                pulse_rem_reg <= (pr != '0) ? pr - 16'd1 : pr;
            end
            if (cmd.hist_add && recorded_reg)
            begin
                sum_reg <= sum_reg + SW'(hist_val);
                if (hist_val > max_reg)
                    max_reg <= hist_val;
            end
            if (cmd.finish && recorded_reg)
            begin
                delay_reg <= sum_reg[SW-1:HW];
                if (timed_out_reg)
                    timeout_reg <= (to_sum >= {1'b0, max_timeout_reg})
                                   ? min_timeout_reg : to_sum[23:0];
                else
                    timeout_reg <= max_div;
            end
            if (cmd.advance)
            begin
                wptr_reg <= wptr_reg + 1'b1;
                if (wptr_reg == '1)
                    wrapped_reg <= 1'b1;
            end
        end
    end

    assign sts.recorded = recorded_reg;
    assign sts.delay_nz = (recorded_reg ? (sum_reg[SW-1:HW] != '0)
                                        : (delay_reg != '0));

    always_comb
    begin
        out_item                 = '0;
        out_item.loop_pulse      = pulse_reg;
        out_item.measured_delay  = delay_reg;
        out_item.new_measurement = recorded_reg;
        out_item.chan0_out       = held_reg[0];
        out_item.chan1_out       = held_reg[1];
        out_item.chan2_out       = held_reg[2];
        out_item.chan3_out       = held_reg[3];
        out_item.chan4_out       = held_reg[4];
        out_item.chan5_out       = held_reg[5];
        out_item.chan6_out       = held_reg[6];
    end

endmodule

// ----- src/loopback_latency_compensator.sv -----
// Top level of the loopback latency compensator
//   channel | dir | handshake             | payload
//   in      | in  | in_valid / in_ready   | in_item_t
//   out     | out | out_valid / out_ready | out_item_t
//   cfg     | in  | cfg_we                | cfg_index, cfg_data
// From accept to result an item passes the history scan (every entry only when a
// duration is recorded) and the finish step, then, when the delay is nonzero, a tap
// of each channel in turn (one delay store port shared by the channels) and a drain step.
// Reset is asynchronous; store entries not yet written read as zero, tracked by
// a wrap mark on the write pointer.
// A result waits in the output register; the next item is taken the cycle after it leaves.
module loopback_latency_compensator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  llc_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output llc_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    llc_pkg::llc_cmd_t cmd;
    llc_pkg::llc_sts_t sts;

    llc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    llc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_item  (out_data)
    );

endmodule

// ----- tb/sv/loopback_latency_compensator_test.sv -----
// Self-checking testbench for the loopback latency compensator: directed table, then random ticks
module loopback_latency_compensator_test;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    llc_pkg::in_item_t   in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    llc_pkg::out_item_t  out_data;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = llc_pkg::REG_PULSE_LENGTH;
    logic [23:0]         cfg_data = '0;

    loopback_latency_compensator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    typedef struct {
        llc_pkg::out_item_t val;
    } tick_result_t;

    tick_result_t expected_ticks[$];
    int  errors;
    int  ticks_sent;
    int  ticks_checked;
    int  records_seen;
    int  mirror_ticks;
    bit  quiet;
    bit  use_fixed;
    tick_result_t fixed_val;

    // compensator shadow: registers
    logic [15:0] m_pulse_len;
    logic [23:0] m_min_to, m_step_to, m_max_to;
    logic signed [15:0] m_hi_th, m_lo_th;
    // compensator shadow: state
    logic [1:0]  m_phase;
    logic [23:0] m_wait, m_timeout, m_delay;
    logic [23:0] m_hist [llc_pkg::HISTORY_LEN];
    int unsigned m_hptr;
    logic [15:0] m_pulse_left;
    logic [15:0] tap_mem [llc_pkg::CHANNELS][llc_pkg::DELAY_DEPTH];
    int unsigned m_wptr;
    logic [15:0] m_held [llc_pkg::CHANNELS];

    task automatic shadow_reset();
        m_pulse_len = 16'd240;
        m_min_to = 24'd9600;
        m_step_to = 24'd48000;
        m_max_to = 24'd58982;
        m_hi_th = 16'sd16384;
        m_lo_th = 16'sd3277;
        m_phase = 2'd0;
        m_wait = '0;
        m_timeout = 24'd9600;
        foreach (m_hist[i]) m_hist[i] = '0;
        m_hptr = 0;
        m_delay = '0;
        m_pulse_left = '0;
        foreach (tap_mem[c, a]) tap_mem[c][a] = '0;
        m_wptr = 0;
        foreach (m_held[i]) m_held[i] = '0;
    endtask

    task automatic record_duration();
        longint unsigned total;
        logic [23:0] peak;
        longint unsigned t;
        bit missed;
        missed = m_wait > m_timeout;
        total = 0;
        peak = '0;
        m_hist[m_hptr] = m_wait;
        m_hptr = (m_hptr + 1) % llc_pkg::HISTORY_LEN;
        for (int i = 0; i < llc_pkg::HISTORY_LEN; i++)
        begin
            total += m_hist[i];
            if (m_hist[i] > peak) peak = m_hist[i];
        end
        m_delay = 24'(total / llc_pkg::HISTORY_LEN);
        if (missed)
        begin
            t = longint'(m_timeout) + longint'(m_step_to);
            m_timeout = (t >= m_max_to) ? m_min_to : 24'(t);
        end
        else
        begin
            t = (longint'(peak) * 11) / 10;
            m_timeout = (t > llc_pkg::MAX24) ? llc_pkg::MAX24 : 24'(t);
        end
    endtask

    function automatic logic [15:0] chan_of(llc_pkg::in_item_t it, int ch);
        case (ch)
            0: return it.chan0_in;
            1: return it.chan1_in;
            2: return it.chan2_in;
            3: return it.chan3_in;
            4: return it.chan4_in;
            5: return it.chan5_in;
            default: return it.chan6_in;
        endcase
    endfunction

    task automatic compensate_tick(input llc_pkg::in_item_t it, output tick_result_t res);
        bit measuring;
        bit recorded;
        bit pulse;
        int unsigned idx, rp;
        measuring = !it.mirror_enable && it.loop_patched && !it.reset_pressed;
        recorded = 1'b0;
        if (measuring)
        begin
            if (m_phase == 2'd1)
            begin
                if (m_wait < llc_pkg::MAX24) m_wait++;
                if (it.loop_level > m_hi_th || m_wait > m_timeout)
                begin
                    record_duration();
                    recorded = 1'b1;
                    m_phase = 2'd2;
                end
            end
            else if (m_phase == 2'd2)
            begin
                if (it.loop_level < m_lo_th) m_phase = 2'd0;
            end
            else
            begin
                if (m_pulse_len > m_pulse_left) m_pulse_left = m_pulse_len;
                m_wait = '0;
                m_phase = 2'd1;
            end
        end
        else
        begin
            m_phase = 2'd0;
            if (it.mirror_enable) m_delay = it.mirror_delay;
        end
        pulse = m_pulse_left != 0;
        if (pulse) m_pulse_left--;
        if (m_delay > 0)
        begin
            idx = (m_delay > llc_pkg::DELAY_DEPTH - 1) ? llc_pkg::DELAY_DEPTH - 1 : m_delay;
            rp = (m_wptr + llc_pkg::DELAY_DEPTH - idx) % llc_pkg::DELAY_DEPTH;
            for (int ch = 0; ch < llc_pkg::CHANNELS; ch++)
            begin
                tap_mem[ch][m_wptr] = chan_of(it, ch);
                m_held[ch] = tap_mem[ch][rp];
            end
            m_wptr = (m_wptr + 1) % llc_pkg::DELAY_DEPTH;
        end
        res.val.loop_pulse = pulse;
        res.val.measured_delay = m_delay;
        res.val.new_measurement = recorded;
        res.val.chan0_out = m_held[0];
        res.val.chan1_out = m_held[1];
        res.val.chan2_out = m_held[2];
        res.val.chan3_out = m_held[3];
        res.val.chan4_out = m_held[4];
        res.val.chan5_out = m_held[5];
        res.val.chan6_out = m_held[6];
    endtask

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // accept side: advance the shadow on every accepted item
    always @(posedge clk)
    begin
        tick_result_t r;
        if (rst_n && in_valid && in_ready)
        begin
            compensate_tick(in_data, r);
            if (use_fixed) r = fixed_val;
            if (in_data.mirror_enable) mirror_ticks++;
            expected_ticks.push_back(r);
        end
    end

    // result side
    always @(posedge clk)
    begin
        tick_result_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_ticks.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
            end
            else
            begin
                w = expected_ticks.pop_front();
                ticks_checked++;
                if (out_data.new_measurement) records_seen++;
                check_field("loop_pulse", w.val.loop_pulse, out_data.loop_pulse);
                check_field("measured_delay", w.val.measured_delay, out_data.measured_delay);
                check_field("new_measurement", w.val.new_measurement,
                            out_data.new_measurement);
                check_field("chan0_out", w.val.chan0_out, out_data.chan0_out);
                check_field("chan1_out", w.val.chan1_out, out_data.chan1_out);
                check_field("chan2_out", w.val.chan2_out, out_data.chan2_out);
                check_field("chan3_out", w.val.chan3_out, out_data.chan3_out);
                check_field("chan4_out", w.val.chan4_out, out_data.chan4_out);
                check_field("chan5_out", w.val.chan5_out, out_data.chan5_out);
                check_field("chan6_out", w.val.chan6_out, out_data.chan6_out);
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 30);
    end

    task automatic send_tick(input llc_pkg::in_item_t it);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!(in_valid && in_ready));
        ticks_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input llc_pkg::reg_index_t idx, input logic [23:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            llc_pkg::REG_PULSE_LENGTH: m_pulse_len = value[15:0];
            llc_pkg::REG_MIN_TIMEOUT:  m_min_to = value;
            llc_pkg::REG_TIMEOUT_STEP: m_step_to = value;
            llc_pkg::REG_MAX_TIMEOUT:  m_max_to = value;
            llc_pkg::REG_HIGH_THRESH:  m_hi_th = value[15:0];
            default:                   m_lo_th = value[15:0];
        endcase
    endtask

    task automatic write_all(logic [15:0] pl, logic [23:0] mn, logic [23:0] st,
                             logic [23:0] mx, logic [15:0] hi, logic [15:0] lo);
        write_reg(llc_pkg::REG_PULSE_LENGTH, {8'd0, pl});
        write_reg(llc_pkg::REG_MIN_TIMEOUT, mn);
        write_reg(llc_pkg::REG_TIMEOUT_STEP, st);
        write_reg(llc_pkg::REG_MAX_TIMEOUT, mx);
        write_reg(llc_pkg::REG_HIGH_THRESH, {8'd0, hi});
        write_reg(llc_pkg::REG_LOW_THRESH, {8'd0, lo});
    endtask

    function automatic llc_pkg::in_item_t tick_of(logic signed [15:0] lvl, bit patched,
                                                  bit mirror, logic [23:0] md, bit held,
                                                  logic [15:0] chans);
        llc_pkg::in_item_t it;
        it.loop_level = lvl;
        it.loop_patched = patched;
        it.mirror_enable = mirror;
        it.mirror_delay = md;
        it.reset_pressed = held;
        it.chan0_in = chans;
        it.chan1_in = ~chans;
        it.chan2_in = chans ^ 16'h5555;
        it.chan3_in = chans + 16'd3;
        it.chan4_in = 16'h8000;
        it.chan5_in = 16'h7FFF;
        it.chan6_in = -chans;
        return it;
    endfunction

    function automatic llc_pkg::in_item_t random_tick();
        llc_pkg::in_item_t it;
        logic [159:0] raw;
        int r;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(llc_pkg::in_item_t)-1:0];
        r = $urandom_range(99);
        it.loop_patched = 1'b1;
        it.mirror_enable = 1'b0;
        it.reset_pressed = 1'b0;
        if (r < 8)
        begin
            it.mirror_enable = 1'b1;
            case ($urandom_range(9))
                0: it.mirror_delay = llc_pkg::MAX24;
                1: it.mirror_delay = 24'd65535;
                2: it.mirror_delay = '0;
                default: it.mirror_delay = 24'($urandom_range(1, 300));
            endcase
        end
        else if (r < 12)
            it.reset_pressed = 1'b1;
        else if (r < 15)
            it.loop_patched = 1'b0;
        r = $urandom_range(99);
        if (r < 15)
            it.loop_level = 16'sh7FFF - 16'($urandom_range(100));
        else if (r < 70)
            it.loop_level = 16'sh8000 + 16'($urandom_range(200));
        return it;
    endfunction

    localparam int N_TABLE = 20;
    llc_pkg::in_item_t table_rows [N_TABLE];

    initial
    begin
        errors = 0;
        ticks_sent = 0;
        ticks_checked = 0;
        records_seen = 0;
        mirror_ticks = 0;
        quiet = 1'b0;
        use_fixed = 1'b0;
        shadow_reset();
        fixed_val.val = '0;

        table_rows[0]  = tick_of(16'sd0, 1'b0, 1'b0, '0, 1'b0, 16'h1234);
        table_rows[1]  = tick_of(16'sh7FFF, 1'b1, 1'b0, llc_pkg::MAX24, 1'b1, 16'hFFFF);
        table_rows[2]  = tick_of(16'sh8000, 1'b1, 1'b0, '0, 1'b0, 16'h0000);
        table_rows[3]  = tick_of(16'sh8000, 1'b1, 1'b0, '0, 1'b0, 16'h0001);
        table_rows[4]  = tick_of(16'sd16384, 1'b1, 1'b0, '0, 1'b0, 16'h8000);
        table_rows[5]  = tick_of(16'sd16385, 1'b1, 1'b0, '0, 1'b0, 16'h7FFF);
        table_rows[6]  = tick_of(16'sd3277, 1'b1, 1'b0, '0, 1'b0, 16'hAAAA);
        table_rows[7]  = tick_of(16'sd3276, 1'b1, 1'b0, '0, 1'b0, 16'h5555);
        table_rows[8]  = tick_of(16'sd0, 1'b1, 1'b0, '0, 1'b0, 16'h0F0F);
        table_rows[9]  = tick_of(16'sh7FFF, 1'b1, 1'b0, '0, 1'b0, 16'hF0F0);
        table_rows[10] = tick_of(16'sd0, 1'b0, 1'b0, '0, 1'b0, 16'h00FF);
        table_rows[11] = tick_of(16'sd0, 1'b1, 1'b1, 24'd1, 1'b0, 16'hFF00);
        table_rows[12] = tick_of(16'sd0, 1'b1, 1'b1, 24'd1, 1'b0, 16'h1111);
        table_rows[13] = tick_of(16'sd0, 1'b1, 1'b1, 24'd2, 1'b0, 16'h2222);
        table_rows[14] = tick_of(16'sd0, 1'b1, 1'b1, '0, 1'b0, 16'h3333);
        table_rows[15] = tick_of(16'sd0, 1'b1, 1'b1, '0, 1'b0, 16'h4444);
        table_rows[16] = tick_of(16'sd0, 1'b1, 1'b1, 24'd65535, 1'b0, 16'h6666);
        table_rows[17] = tick_of(16'sd0, 1'b1, 1'b1, llc_pkg::MAX24, 1'b0, 16'h7777);
        table_rows[18] = tick_of(16'sd0, 1'b1, 1'b1, 24'd3, 1'b1, 16'h9999);
        table_rows[19] = tick_of(16'sd0, 1'b0, 1'b0, 24'd5, 1'b1, 16'hCCCC);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_TABLE; i++)
        begin
            use_fixed = (i < 2);
            send_tick(table_rows[i]);
        end
        use_fixed = 1'b0;
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_all(16'd240, 24'd9600, 24'd48000, 24'd58982, 16'd16384, 16'd3277);
                1: write_all(16'd1, 24'd3, 24'd2, 24'd12, 16'd0, 16'hFF9C);
                2: write_all(16'd7, 24'd1, 24'd1, 24'd1, 16'h8000, 16'h7FFF);
                3: write_all(16'd65535, llc_pkg::MAX24, llc_pkg::MAX24, llc_pkg::MAX24,
                             16'h7FFF, 16'h7FFF);
                4: write_all(16'd3, 24'd1, 24'd1, 24'd1, 16'h8000, 16'h8000);
                default: write_all(16'd20, 24'd4, 24'd5, 24'd40, 16'd8000, 16'd100);
            endcase
            quiet = (ph == 2);
            for (int k = 0; k < 155; k++) send_tick(random_tick());
            quiet = 1'b0;
            drain();
        end

        $display("ran %0d ticks, %0d results checked, %0d durations recorded, %0d mirror ticks",
                 ticks_sent, ticks_checked, records_seen, mirror_ticks);
        $display("register settings covered default, tight timeouts and both threshold extremes");
        if (errors == 0 && expected_ticks.size() == 0)
            $display("loopback_latency_compensator_test: clean");
        else
        begin
            if (expected_ticks.size() != 0)
                $error("%0d results never arrived", expected_ticks.size());
            $display("loopback_latency_compensator_test: errors");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("loopback_latency_compensator_test: errors");
        $finish;
    end

endmodule
